>>> rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared constants and types for the segment intersection test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  // Default coordinate width (signed Q8.8).
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Parallel tolerance register.
  localparam int unsigned TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd8;

  // Load enables for the two register stages inside a product unit.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } sit_stage_en_t;

endpackage

`default_nettype wire

>>> rtl/sit_pair_if.sv
// ----------------------------------------------------------------------------
// Segment pair channel
// Valid/ready channel that carries the endpoints of segments A and B.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_pair_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] a_start_x;
  logic [COORD_WIDTH-1:0] a_start_y;
  logic [COORD_WIDTH-1:0] a_end_x;
  logic [COORD_WIDTH-1:0] a_end_y;
  logic [COORD_WIDTH-1:0] b_start_x;
  logic [COORD_WIDTH-1:0] b_start_y;
  logic [COORD_WIDTH-1:0] b_end_x;
  logic [COORD_WIDTH-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sit_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the one-bit collision verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_result_if;
  logic valid;
  logic ready;
  logic collide;

  modport source (output valid, collide, input ready);
  modport sink   (input valid, collide, output ready);
endinterface

`default_nettype wire

>>> rtl/sit_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the parallel tolerance register.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_cfg_if
  import sit_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TOL_WIDTH-1:0] parallel_tolerance;

  modport source (output valid, parallel_tolerance, input ready);
  modport sink   (input valid, parallel_tolerance, output ready);
endinterface

`default_nettype wire

>>> rtl/sit_dot2.sv
// ----------------------------------------------------------------------------
// Two-term product unit
// Registers a0*b0 and a1*b1, then registers their sum or difference.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_dot2
  import sit_pkg::*;
#(
  parameter int unsigned AW       = 17,
  parameter int unsigned BW       = 17,
  parameter bit          SUBTRACT = 1'b1
) (
  input  wire logic                     clk,
  input  wire sit_stage_en_t            en,
  input  wire logic signed [AW-1:0]     a0,
  input  wire logic signed [BW-1:0]     b0,
  input  wire logic signed [AW-1:0]     a1,
  input  wire logic signed [BW-1:0]     b1,
  output logic signed [AW+BW:0]         result
);

  logic signed [AW+BW-1:0] prod0;
  logic signed [AW+BW-1:0] prod1;

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      prod0 <= a0 * b0;
      prod1 <= a1 * b1;
    end
  end

  // One extra bit keeps the sum or difference exact.
  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      if (SUBTRACT) begin
        result <= {prod0[AW+BW-1], prod0} - {prod1[AW+BW-1], prod1};
      end else begin
        result <= {prod0[AW+BW-1], prod0} + {prod1[AW+BW-1], prod1};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection test
// Five-stage pipeline that decides whether two 2D line segments touch.
// ----------------------------------------------------------------------------
// A segment pair is taken on every cycle in which the input channel is
// ready, so when nothing downstream stalls a continuous stream runs at one
// pair per clock. Each pair passes through the five register stages: operand
// differences, products, product sums, sign and magnitude decisions, and the
// output register. The first of them is loaded at the transfer itself. Every
// stage carries its own valid bit and holds its item only while the stage
// after it is full and stalled, so a stall on the result channel fills empty
// stages first and the input channel keeps taking pairs until the whole
// pipeline is occupied. The parallel tolerance register may be written at
// any time the block is empty; it takes effect for the next pair. All
// arithmetic is exact, so the verdict matches the fixed-point definition bit
// for bit, including pairs that touch only at an endpoint and segments of
// zero length.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_test
  import sit_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  sit_pair_if.sink  seg,
  sit_cfg_if.sink   cfg,
  sit_result_if.source res
);

  // Differences are one bit wider than a coordinate; a side or cross value
  // is the difference of two products of differences, a projection the sum
  // of two products of a difference and a coordinate.
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned SW = 2 * DW + 1;
  localparam int unsigned PW = DW + CW + 1;

  function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] p,
                                                input logic [CW-1:0] q);
    logic signed [DW-1:0] pe;
    logic signed [DW-1:0] qe;
    pe = signed'({p[CW-1], p});
    qe = signed'({q[CW-1], q});
    return pe - qe;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: the register is always ready to take a write.
  // --------------------------------------------------------------------------
  logic [TOL_WIDTH-1:0] tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg.valid) begin
      tolerance <= cfg.parallel_tolerance;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it loads in the same cycle.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5 = !res.valid || res.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign seg.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (en1) v1 <= seg.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) res.valid <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: coordinates and all operand differences.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic signed [DW-1:0] dax, day, dbx, dby;
  // Endpoints of B relative to the start of A, and of A relative to B.
  logic signed [DW-1:0] ua1x, ua1y, ua2x, ua2y;
  logic signed [DW-1:0] ub1x, ub1y, ub2x, ub2y;

  always_ff @(posedge clk) begin
    if (en1 && seg.valid) begin
      ax1  <= signed'(seg.a_start_x);
      ay1  <= signed'(seg.a_start_y);
      ax2  <= signed'(seg.a_end_x);
      ay2  <= signed'(seg.a_end_y);
      bx1  <= signed'(seg.b_start_x);
      by1  <= signed'(seg.b_start_y);
      bx2  <= signed'(seg.b_end_x);
      by2  <= signed'(seg.b_end_y);
      dax  <= diff(seg.a_end_x, seg.a_start_x);
      day  <= diff(seg.a_end_y, seg.a_start_y);
      dbx  <= diff(seg.b_end_x, seg.b_start_x);
      dby  <= diff(seg.b_end_y, seg.b_start_y);
      ua1x <= diff(seg.b_start_x, seg.a_start_x);
      ua1y <= diff(seg.b_start_y, seg.a_start_y);
      ua2x <= diff(seg.b_end_x, seg.a_start_x);
      ua2y <= diff(seg.b_end_y, seg.a_start_y);
      ub1x <= diff(seg.a_start_x, seg.b_start_x);
      ub1y <= diff(seg.a_start_y, seg.b_start_y);
      ub2x <= diff(seg.a_end_x, seg.b_start_x);
      ub2y <= diff(seg.a_end_y, seg.b_start_y);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2 and 3: products, then their sums and differences.
  // --------------------------------------------------------------------------
  sit_stage_en_t prod_en;

  assign prod_en.mul_en = en2;
  assign prod_en.sum_en = en3;

  // Side of each endpoint of B against the line of A, and the reverse.
  logic signed [SW-1:0] side_a1, side_a2, side_b1, side_b2;
  // Cross product of the two directions.
  logic signed [SW-1:0] dir_cross;
  // Projections of all four endpoints onto the direction of A.
  logic signed [PW-1:0] pa1, pa2, pb1, pb2;

  sit_dot2 #(.AW(DW), .BW(DW), .SUBTRACT(1'b1)) u_side_a1 (
    .clk(clk), .en(prod_en), .a0(dax), .b0(ua1y), .a1(day), .b1(ua1x),
    .result(side_a1)
  );
  sit_dot2 #(.AW(DW), .BW(DW), .SUBTRACT(1'b1)) u_side_a2 (
    .clk(clk), .en(prod_en), .a0(dax), .b0(ua2y), .a1(day), .b1(ua2x),
    .result(side_a2)
  );
  sit_dot2 #(.AW(DW), .BW(DW), .SUBTRACT(1'b1)) u_side_b1 (
    .clk(clk), .en(prod_en), .a0(dbx), .b0(ub1y), .a1(dby), .b1(ub1x),
    .result(side_b1)
  );
  sit_dot2 #(.AW(DW), .BW(DW), .SUBTRACT(1'b1)) u_side_b2 (
    .clk(clk), .en(prod_en), .a0(dbx), .b0(ub2y), .a1(dby), .b1(ub2x),
    .result(side_b2)
  );
  sit_dot2 #(.AW(DW), .BW(DW), .SUBTRACT(1'b1)) u_cross (
    .clk(clk), .en(prod_en), .a0(dax), .b0(dby), .a1(day), .b1(dbx),
    .result(dir_cross)
  );
  sit_dot2 #(.AW(DW), .BW(CW), .SUBTRACT(1'b0)) u_proj_a1 (
    .clk(clk), .en(prod_en), .a0(dax), .b0(ax1), .a1(day), .b1(ay1),
    .result(pa1)
  );
  sit_dot2 #(.AW(DW), .BW(CW), .SUBTRACT(1'b0)) u_proj_a2 (
    .clk(clk), .en(prod_en), .a0(dax), .b0(ax2), .a1(day), .b1(ay2),
    .result(pa2)
  );
  sit_dot2 #(.AW(DW), .BW(CW), .SUBTRACT(1'b0)) u_proj_b1 (
    .clk(clk), .en(prod_en), .a0(dax), .b0(bx1), .a1(day), .b1(by1),
    .result(pb1)
  );
  sit_dot2 #(.AW(DW), .BW(CW), .SUBTRACT(1'b0)) u_proj_b2 (
    .clk(clk), .en(prod_en), .a0(dax), .b0(bx2), .a1(day), .b1(by2),
    .result(pb2)
  );

  // --------------------------------------------------------------------------
  // Stage 4: signs, tolerance window and interval comparisons.
  // --------------------------------------------------------------------------
  // A pair is rejected when both side values of one test are non-zero and
  // share a sign; a zero side value means an endpoint lies on the line.
  logic reject_a_c, reject_b_c, in_tol_c;
  logic signed [SW-1:0] tol_pos, tol_neg;

  assign reject_a_c = (side_a1 > 0 && side_a2 > 0) || (side_a1 < 0 && side_a2 < 0);
  assign reject_b_c = (side_b1 > 0 && side_b2 > 0) || (side_b1 < 0 && side_b2 < 0);

  // |cross| < tolerance, written as a window so that no absolute value is
  // formed. A tolerance of zero gives an empty window.
  assign tol_pos  = signed'({{(SW-TOL_WIDTH){1'b0}}, tolerance});
  assign tol_neg  = -tol_pos;
  assign in_tol_c = (dir_cross < tol_pos) && (dir_cross > tol_neg);

  logic       reject, parallel, a_ordered, b_ordered;
  // b_le_a[i][j]: projection of B endpoint i is at most that of A endpoint j.
  logic [1:0][1:0] b_le_a;
  logic [1:0][1:0] a_le_b;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      reject       <= reject_a_c || reject_b_c;
      parallel     <= in_tol_c;
      a_ordered    <= pa1 <= pa2;
      b_ordered    <= pb1 <= pb2;
      b_le_a[0][0] <= pb1 <= pa1;
      b_le_a[0][1] <= pb1 <= pa2;
      b_le_a[1][0] <= pb2 <= pa1;
      b_le_a[1][1] <= pb2 <= pa2;
      a_le_b[0][0] <= pa1 <= pb1;
      a_le_b[0][1] <= pa1 <= pb2;
      a_le_b[1][0] <= pa2 <= pb1;
      a_le_b[1][1] <= pa2 <= pb2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: pick the interval ends and register the verdict.
  // --------------------------------------------------------------------------
  logic min_a_idx, max_a_idx, min_b_idx, max_b_idx;
  logic overlap, collide_c;

  assign min_a_idx = !a_ordered;
  assign max_a_idx = a_ordered;
  assign min_b_idx = !b_ordered;
  assign max_b_idx = b_ordered;
  assign overlap   = b_le_a[min_b_idx][max_a_idx] && a_le_b[min_a_idx][max_b_idx];
  assign collide_c = !reject && (!parallel || overlap);

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      res.collide <= collide_c;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every accepted pair occupies the first stage on the next cycle.
  a_entry_taken: assert property (@(posedge clk) disable iff (rst)
    (seg.valid && seg.ready) |=> v1)
    else $error("accepted pair did not enter the first stage");

  // A pair rejected by a side test never reports a collision.
  a_reject_clear: assert property (@(posedge clk) disable iff (rst)
    (v4 && en5 && reject) |=> (res.valid && !res.collide))
    else $error("side-rejected pair reported a collision");

  // Exactly parallel directions fall inside any non-zero tolerance.
  a_zero_cross_tol: assert property (@(posedge clk) disable iff (rst)
    (v3 && dir_cross == '0 && tolerance != '0) |-> in_tol_c)
    else $error("zero cross product outside the tolerance window");

  // A result only appears when the decision stage held an item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(v4))
    else $error("result appeared without an item in the decision stage");

endmodule

`default_nettype wire
